@@ src/ddm_pkg.sv @@
package ddm_pkg;

  // Field widths
  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int WSPD_W   = 7;
  localparam int DRIVE_W  = 9;
  localparam int SPEED_W  = 16;
  localparam int RAD_W    = 11;
  localparam int CFG_IDX_W = 2;

  // Divider widths: numerator is 100 * speed, denominator is 2 * radius
  localparam int NUM_W    = 16;
  localparam int DEN_W    = RAD_W + 1;
  localparam int QUO_W    = NUM_W + 1;
  localparam int CNT_W    = $clog2(NUM_W);
  localparam int CLAMP_W  = QUO_W + 1;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_SET_SPEED   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET_STEER   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ALTER_SPEED = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STOP        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RUN_STATE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TICK        = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANDER_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBST_DIST    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WANDER_PER   = 2'd3;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] RST_SPEED_LIMIT  = 8'd200;
  localparam logic [WSPD_W-1:0] RST_WANDER_SPEED = 7'd65;
  localparam logic [BYTE_W-1:0] RST_OBST_DIST    = 8'd30;
  localparam logic [BYTE_W-1:0] RST_WANDER_PER   = 8'd7;

  // Run states
  localparam logic RUN_NORMAL = 1'b0;

  // Steering map constants
  localparam logic signed [BYTE_W-1:0] STEER_DEADBAND = 8'sd5;
  localparam logic signed [BYTE_W-1:0] STEER_MAX      = 8'sd127;
  localparam logic signed [RAD_W-1:0]  SPIN_RADIUS    = 11'sd762;
  localparam logic signed [RAD_W-1:0]  RAD_POS_BASE   = 11'sd742;
  localparam logic signed [RAD_W-1:0]  RAD_NEG_BASE   = -11'sd782;
  localparam logic signed [RAD_W-1:0]  RAD_STEP       = 11'sd6;
  localparam logic signed [NUM_W-1:0]  MIX_GAIN       = 16'sd100;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MIX,
    ST_DIV,
    ST_OUT
  } ddm_state_t;

  // Divider request and response
  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quo;
  } div_rsp_t;

  // Steering value to turn radius.
  function automatic logic signed [RAD_W-1:0] steer_radius(
    input logic signed [BYTE_W-1:0] d
  );
    logic signed [RAD_W-1:0] dx;
    logic signed [RAD_W-1:0] res;
    dx = {{(RAD_W-BYTE_W){d[BYTE_W-1]}}, d};
    if (d >= -STEER_DEADBAND && d <= STEER_DEADBAND) begin
      res = '0;
    end else if (d == STEER_MAX) begin
      res = -SPIN_RADIUS;
    end else if (d == -STEER_MAX) begin
      res = SPIN_RADIUS;
    end else if (d >= 0) begin
      res = RAD_POS_BASE - RAD_STEP * dx;
    end else begin
      res = RAD_NEG_BASE - RAD_STEP * dx;
    end
    return res;
  endfunction

  // Saturate a speed to plus or minus the limit.
  function automatic logic signed [DRIVE_W-1:0] clamp_speed(
    input logic signed [CLAMP_W-1:0] v,
    input logic [BYTE_W-1:0]         lim
  );
    logic signed [CLAMP_W-1:0] hi;
    logic signed [CLAMP_W-1:0] lo;
    logic signed [CLAMP_W-1:0] res;
    hi = $signed({{(CLAMP_W-BYTE_W){1'b0}}, lim});
    lo = -hi;
    if (v > hi) begin
      res = hi;
    end else if (v < lo) begin
      res = lo;
    end else begin
      res = v;
    end
    return res[DRIVE_W-1:0];
  endfunction

endpackage

@@ src/ddm_if.sv @@
// Command channel
interface ddm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [ddm_pkg::MODE_W-1:0]           mode;
  logic signed [ddm_pkg::BYTE_W-1:0]    amount;
  logic                                 run_state;
  logic                                 first_run;
  logic [ddm_pkg::BYTE_W-1:0]           distance;
  logic signed [ddm_pkg::BYTE_W-1:0]    random_heading;

  modport source(output valid, mode, amount, run_state, first_run, distance,
                 random_heading, input ready);
  modport sink(input valid, mode, amount, run_state, first_run, distance,
               random_heading, output ready);
endinterface

// Result channel
interface ddm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ddm_pkg::DRIVE_W-1:0]   left_drive;
  logic signed [ddm_pkg::DRIVE_W-1:0]   right_drive;
  logic                                 drive_written;
  logic signed [ddm_pkg::SPEED_W-1:0]   speed_setting;
  logic signed [ddm_pkg::RAD_W-1:0]     turn_radius;

  modport source(output valid, left_drive, right_drive, drive_written,
                 speed_setting, turn_radius, input ready);
  modport sink(input valid, left_drive, right_drive, drive_written,
               speed_setting, turn_radius, output ready);
endinterface

// Configuration write channel
interface ddm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [ddm_pkg::CFG_IDX_W-1:0]        index;
  logic [ddm_pkg::BYTE_W-1:0]           data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/differential_drive_mixer_core.sv @@
// Differential-drive steering mixer. Each command item is taken when in_ch is
// ready, executed, and answered by exactly one result item carrying the wheel
// speeds, the requested speed and the turn radius. The block holds one item
// at a time: ready is low from acceptance until the result has been taken.
// After acceptance an item steps through ST_EXEC, ST_OUT if it needs no mix,
// ST_EXEC, ST_MIX, ST_OUT if the mix is straight ahead or a spin on the spot,
// and ST_EXEC, ST_MIX, ST_DIV, ST_OUT if the wheel-speed offset must be
// divided; ST_OUT holds until the output handshake and ST_DIV waits on the
// shared bit-serial divider, which resolves one quotient bit per cycle over a
// 16-bit numerator and flags done with the last bit. Configuration writes are
// accepted at any cycle and should only be issued while no item is in flight.
module differential_drive_mixer_core (
  input logic      clk,
  input logic      rst_n,
  ddm_in_if.sink   in_ch,
  ddm_out_if.source out_ch,
  ddm_cfg_if.sink  cfg_ch
);
  import ddm_pkg::*;

  // Configuration registers
  logic [BYTE_W-1:0]  speed_limit_r;
  logic [WSPD_W-1:0]  wander_speed_r;
  logic [BYTE_W-1:0]  obst_dist_r;
  logic [BYTE_W-1:0]  wander_per_r;

  // Latched command item
  logic [MODE_W-1:0]         mode_r;
  logic signed [BYTE_W-1:0]  amount_r;
  logic                      run_state_r;
  logic                      first_run_r;
  logic [BYTE_W-1:0]         distance_r;
  logic signed [BYTE_W-1:0]  heading_r;

  // Mixer state and its next values
  ddm_state_t                state_r, state_nxt;
  logic signed [SPEED_W-1:0] req_r, req_nxt;
  logic signed [DRIVE_W-1:0] clamped_r, clamped_nxt;
  logic signed [RAD_W-1:0]   radius_r, radius_nxt;
  logic signed [DRIVE_W-1:0] left_r, left_nxt;
  logic signed [DRIVE_W-1:0] right_r, right_nxt;
  logic                      fresh_r, fresh_nxt;
  logic                      cur_r, cur_nxt;
  logic                      prev_r, prev_nxt;
  logic                      pend_r, pend_nxt;
  logic [BYTE_W-1:0]         cnt_r, cnt_nxt;
  logic                      written_r, written_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      in_acc;
  logic                      do_mix;
  logic                      spd_put;
  logic signed [SPEED_W-1:0] spd_val;
  logic signed [SPEED_W-1:0] amt_ext;
  logic signed [SPEED_W-1:0] wspd_ext;
  logic signed [CLAMP_W-1:0] s_ext;
  logic signed [CLAMP_W-1:0] q_ext;

  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign amt_ext  = {{(SPEED_W-BYTE_W){amount_r[BYTE_W-1]}}, amount_r};
  assign wspd_ext = $signed({{(SPEED_W-WSPD_W){1'b0}}, wander_speed_r});
  assign s_ext    = {{(CLAMP_W-DRIVE_W){clamped_r[DRIVE_W-1]}}, clamped_r};
  assign q_ext    = {div_rsp.quo[QUO_W-1], div_rsp.quo};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r  <= RST_SPEED_LIMIT;
      wander_speed_r <= RST_WANDER_SPEED;
      obst_dist_r    <= RST_OBST_DIST;
      wander_per_r   <= RST_WANDER_PER;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        CFG_SPEED_LIMIT:  speed_limit_r  <= cfg_ch.data;
        CFG_WANDER_SPEED: wander_speed_r <= cfg_ch.data[WSPD_W-1:0];
        CFG_OBST_DIST:    obst_dist_r    <= cfg_ch.data;
        CFG_WANDER_PER:   wander_per_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Capture the command item on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r      <= in_ch.mode;
      amount_r    <= in_ch.amount;
      run_state_r <= in_ch.run_state;
      first_run_r <= in_ch.first_run;
      distance_r  <= in_ch.distance;
      heading_r   <= in_ch.random_heading;
    end
  end

  // Sequencer and mixer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      req_r     <= '0;
      clamped_r <= '0;
      radius_r  <= '0;
      left_r    <= '0;
      right_r   <= '0;
      fresh_r   <= 1'b0;
      cur_r     <= RUN_NORMAL;
      prev_r    <= RUN_NORMAL;
      pend_r    <= 1'b0;
      cnt_r     <= '0;
      written_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      req_r     <= req_nxt;
      clamped_r <= clamped_nxt;
      radius_r  <= radius_nxt;
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      fresh_r   <= fresh_nxt;
      cur_r     <= cur_nxt;
      prev_r    <= prev_nxt;
      pend_r    <= pend_nxt;
      cnt_r     <= cnt_nxt;
      written_r <= written_nxt;
    end
  end

  // Next state: command execution, then mixing, through the shared divider where the radius calls for it.
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    clamped_nxt = clamped_r;
    radius_nxt  = radius_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    fresh_nxt   = fresh_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    pend_nxt    = pend_r;
    cnt_nxt     = cnt_r;
    written_nxt = written_r;
    do_mix      = 1'b0;
    spd_put     = 1'b0;
    spd_val     = req_r;
    div_req.start = 1'b0;
    div_req.num   = NUM_W'(clamped_r) * MIX_GAIN;
    div_req.den   = {radius_r, 1'b0};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        written_nxt = 1'b0;
        unique case (mode_r)
          MODE_SET_SPEED: begin
            spd_put = 1'b1;
            spd_val = amt_ext;
            do_mix  = 1'b1;
          end
          MODE_SET_STEER: begin
            radius_nxt = steer_radius(amount_r);
            do_mix     = 1'b1;
          end
          MODE_ALTER_SPEED: begin
            // Only acts once a speed computation has happened.
            if (fresh_r) begin
              spd_put = 1'b1;
              spd_val = req_r + amt_ext;
              do_mix  = 1'b1;
            end
          end
          MODE_STOP: begin
            radius_nxt = '0;
            spd_put    = 1'b1;
            spd_val    = '0;
            do_mix     = 1'b1;
          end
          MODE_RUN_STATE: begin
            cur_nxt  = run_state_r;
            pend_nxt = first_run_r;
          end
          MODE_TICK: begin
            // A change of run state stops both wheels first.
            if (cur_r != prev_r) begin
              prev_nxt    = cur_r;
              left_nxt    = '0;
              right_nxt   = '0;
              written_nxt = 1'b1;
            end
            if (cur_r == RUN_NORMAL) begin
              written_nxt = 1'b1;
            end else begin
              if (pend_r) begin
                spd_put  = 1'b1;
                spd_val  = wspd_ext;
                pend_nxt = 1'b0;
                do_mix   = 1'b1;
              end
              if (distance_r <= obst_dist_r) begin
                // Obstacle ahead: back off straight.
                spd_put     = 1'b1;
                spd_val     = -wspd_ext;
                radius_nxt  = '0;
                do_mix      = 1'b1;
                written_nxt = 1'b1;
              end else if (cnt_r >= wander_per_r) begin
                // Period expired: take a new heading.
                cnt_nxt     = '0;
                spd_put     = 1'b1;
                spd_val     = wspd_ext;
                radius_nxt  = steer_radius(heading_r);
                do_mix      = 1'b1;
                written_nxt = 1'b1;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
          default: ;
        endcase
        if (spd_put) begin
          req_nxt     = spd_val;
          clamped_nxt = clamp_speed({{(CLAMP_W-SPEED_W){spd_val[SPEED_W-1]}}, spd_val},
                                    speed_limit_r);
        end
        if (do_mix) begin
          fresh_nxt = 1'b1;
          state_nxt = ST_MIX;
        end else begin
          state_nxt = ST_OUT;
        end
      end

      ST_MIX: begin
        // Straight and spin radii need no division.
        priority if (radius_r == '0) begin
          left_nxt  = clamp_speed(s_ext, speed_limit_r);
          right_nxt = clamp_speed(s_ext, speed_limit_r);
          state_nxt = ST_OUT;
        end else if (radius_r == SPIN_RADIUS) begin
          left_nxt  = clamp_speed(s_ext, speed_limit_r);
          right_nxt = clamp_speed(-s_ext, speed_limit_r);
          state_nxt = ST_OUT;
        end else if (radius_r == -SPIN_RADIUS) begin
          left_nxt  = clamp_speed(-s_ext, speed_limit_r);
          right_nxt = clamp_speed(s_ext, speed_limit_r);
          state_nxt = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          left_nxt  = clamp_speed(s_ext + q_ext, speed_limit_r);
          right_nxt = clamp_speed(s_ext - q_ext, speed_limit_r);
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Shared divider for the wheel-speed offset
  ddm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Result item straight from the state registers
  assign out_ch.valid         = (state_r == ST_OUT);
  assign out_ch.left_drive    = left_r;
  assign out_ch.right_drive   = right_r;
  assign out_ch.drive_written = written_r;
  assign out_ch.speed_setting = req_r;
  assign out_ch.turn_radius   = radius_r;

  a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("new item accepted while a result is pending");
  a_acc_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_EXEC))
    else $error("accepted item not executed next cycle");
  a_div_from_mix : assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == ST_MIX && radius_r != '0))
    else $error("divider started outside the mixing step");
  a_written_tick : assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.drive_written) |-> (mode_r == MODE_TICK))
    else $error("drive write flagged for a non-tick item");

endmodule

@@ src/ddm_div.sv @@
module ddm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ddm_pkg::div_req_t req_i,
  output ddm_pkg::div_rsp_t rsp_o
);
  import ddm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [NUM_W-1:0]     dvd_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W-1:0]     rem_r;
  logic                 neg_r;

  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 ge;
  logic [NUM_W-1:0]     num_mag;
  logic [DEN_W-1:0]     den_mag;
  logic [QUO_W-1:0]     quo_pos;

  // Operand magnitudes at start
  assign num_mag = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
  assign den_mag = req_i.den[DEN_W-1] ? DEN_W'(-req_i.den) : DEN_W'(req_i.den);

  // One restoring step: shift in the next dividend bit and trial-subtract.
  assign rem_sh  = {rem_r, dvd_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (req_i.start) begin
      dvd_r <= num_mag;
      den_r <= den_mag;
      rem_r <= '0;
      neg_r <= req_i.num[NUM_W-1] ^ req_i.den[DEN_W-1];
    end else if (busy_r) begin
      dvd_r <= {dvd_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  // Truncating quotient with the sign restored
  assign quo_pos    = {1'b0, dvd_r};
  assign rsp_o.done = done_r;
  assign rsp_o.quo  = neg_r ? $signed(-quo_pos) : $signed(quo_pos);

  a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
    req_i.start |-> !busy_r)
    else $error("divider started while busy");
  a_done_ends : assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req_i.start && cnt_r == CNT_W'(NUM_W - 1)) |=> (done_r && !busy_r))
    else $error("divider did not finish after its last step");
  a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

@@ bench/differential_drive_mixer_core_tb.sv @@
`timescale 1ns / 1ps
module differential_drive_mixer_core_tb;
  import ddm_pkg::*;

  // Unused command codes, which must leave the state alone.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic RUN_WANDER = !RUN_NORMAL;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic signed [BYTE_W-1:0] amount;
    logic                     run_state;
    logic                     first_run;
    logic [BYTE_W-1:0]        distance;
    logic signed [BYTE_W-1:0] heading;
  } command_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] left;
    logic signed [DRIVE_W-1:0] right;
    logic                      written;
    logic signed [SPEED_W-1:0] speed;
    logic signed [RAD_W-1:0]   radius;
  } drive_t;

  typedef enum {RX_STEADY, RX_COIN, RX_STALLS, RX_SPARSE} rx_style_t;

  // Predicts the wheel drive for every accepted command and checks the results in order.
  class wheel_scoreboard;
    logic [BYTE_W-1:0]         speed_limit;
    logic [WSPD_W-1:0]         wander_speed;
    logic [BYTE_W-1:0]         obstacle_dist;
    logic [BYTE_W-1:0]         wander_period;
    logic signed [SPEED_W-1:0] requested_speed;
    logic signed [DRIVE_W-1:0] drive_speed;
    logic signed [RAD_W-1:0]   radius;
    logic signed [DRIVE_W-1:0] left_speed;
    logic signed [DRIVE_W-1:0] right_speed;
    logic                      speeds_fresh;
    logic                      run_now;
    logic                      run_prev;
    logic                      first_pending;
    logic [BYTE_W-1:0]         wander_count;
    drive_t                    expected_drives[$];
    int                        mismatches;

    function new();
      speed_limit     = RST_SPEED_LIMIT;
      wander_speed    = RST_WANDER_SPEED;
      obstacle_dist   = RST_OBST_DIST;
      wander_period   = RST_WANDER_PER;
      requested_speed = '0;
      drive_speed     = '0;
      radius          = '0;
      left_speed      = '0;
      right_speed     = '0;
      speeds_fresh    = 1'b0;
      run_now         = RUN_NORMAL;
      run_prev        = RUN_NORMAL;
      first_pending   = 1'b0;
      wander_count    = '0;
      mismatches      = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
      case (idx)
        CFG_SPEED_LIMIT:  speed_limit = data;
        CFG_WANDER_SPEED: wander_speed = data[WSPD_W-1:0];
        CFG_OBST_DIST:    obstacle_dist = data;
        CFG_WANDER_PER:   wander_period = data;
        default: ;
      endcase
    endfunction

    function int saturate(int s);
      int lim;
      lim = int'(speed_limit);
      if (s > lim) return lim;
      if (s < -lim) return -lim;
      return s;
    endfunction

    // Split the clamped speed between the wheels according to the turn radius.
    function void mix_wheels();
      int s, r, q, l, rt, spin;
      s = int'(drive_speed);
      r = int'(radius);
      spin = int'(SPIN_RADIUS);
      if (r == 0) begin
        l = s;
        rt = s;
      end else if (r == spin) begin
        l = s;
        rt = -s;
      end else if (r == -spin) begin
        l = -s;
        rt = s;
      end else begin
        q = (int'(MIX_GAIN) * s) / (2 * r);
        l = s + q;
        rt = s - q;
      end
      left_speed = DRIVE_W'(saturate(l));
      right_speed = DRIVE_W'(saturate(rt));
      speeds_fresh = 1'b1;
    endfunction

    function void apply_speed(int s);
      requested_speed = SPEED_W'(s);
      drive_speed = DRIVE_W'(saturate(int'(requested_speed)));
      mix_wheels();
    endfunction

    // Steering to radius: a dead band, spin at the ends, linear in between.
    function void apply_steering(int d);
      int band, top;
      band = int'(STEER_DEADBAND);
      top = int'(STEER_MAX);
      if (d >= -band && d <= band) begin
        radius = '0;
      end else if (d == top) begin
        radius = -SPIN_RADIUS;
      end else if (d == -top) begin
        radius = SPIN_RADIUS;
      end else if (d >= 0) begin
        radius = RAD_W'(int'(RAD_POS_BASE) - int'(RAD_STEP) * d);
      end else begin
        radius = RAD_W'(int'(RAD_NEG_BASE) - int'(RAD_STEP) * d);
      end
      mix_wheels();
    endfunction

    function void take_command(command_t c);
      logic   written;
      drive_t want;
      written = 1'b0;
      case (c.mode)
        MODE_SET_SPEED: apply_speed(int'(c.amount));
        MODE_SET_STEER: apply_steering(int'(c.amount));
        MODE_ALTER_SPEED: begin
          // Only acts once speeds have been computed.
          if (speeds_fresh) begin
            speeds_fresh = 1'b0;
            apply_speed(int'(requested_speed) + int'(c.amount));
          end
        end
        MODE_STOP: begin
          apply_steering(0);
          apply_speed(0);
        end
        MODE_RUN_STATE: begin
          run_now = c.run_state;
          first_pending = c.first_run;
        end
        MODE_TICK: begin
          // A change of run state stops both wheels before anything else.
          if (run_now != run_prev) begin
            run_prev = run_now;
            left_speed = '0;
            right_speed = '0;
            written = 1'b1;
          end
          if (run_now == RUN_NORMAL) begin
            written = 1'b1;
          end else begin
            if (first_pending) begin
              apply_speed(int'(wander_speed));
              first_pending = 1'b0;
            end
            if (c.distance <= obstacle_dist) begin
              apply_speed(-int'(wander_speed));
              apply_steering(0);
              written = 1'b1;
            end else if (wander_count >= wander_period) begin
              wander_count = '0;
              apply_speed(int'(wander_speed));
              apply_steering(int'(c.heading));
              written = 1'b1;
            end else begin
              wander_count = wander_count + 1'b1;
            end
          end
        end
        default: ;
      endcase
      want.left = left_speed;
      want.right = right_speed;
      want.written = written;
      want.speed = requested_speed;
      want.radius = radius;
      expected_drives.push_back(want);
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (expected_drives.size() == 0) begin
        $error("drive item with none expected: left_drive %0d right_drive %0d",
               got.left, got.right);
        mismatches++;
        return;
      end
      want = expected_drives.pop_front();
      if (got.left !== want.left) begin
        $error("left_drive: expected %0d, got %0d", want.left, got.left);
        mismatches++;
      end
      if (got.right !== want.right) begin
        $error("right_drive: expected %0d, got %0d", want.right, got.right);
        mismatches++;
      end
      if (got.written !== want.written) begin
        $error("drive_written: expected %0d, got %0d", want.written, got.written);
        mismatches++;
      end
      if (got.speed !== want.speed) begin
        $error("speed_setting: expected %0d, got %0d", want.speed, got.speed);
        mismatches++;
      end
      if (got.radius !== want.radius) begin
        $error("turn_radius: expected %0d, got %0d", want.radius, got.radius);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ddm_in_if  in_ch();
  ddm_out_if out_ch();
  ddm_cfg_if cfg_ch();

  differential_drive_mixer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wheel_scoreboard sb;
  int items_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  rx_style_t rx_style = RX_STEADY;
  int rx_style_left = 0;
  int rx_hold = 0;
  int rx_beat = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sample the channels at the rising edge.
  always @(posedge clk) begin
    command_t cmd;
    drive_t   got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.write_register(cfg_ch.index, cfg_ch.data);
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd.mode = in_ch.mode;
        cmd.amount = in_ch.amount;
        cmd.run_state = in_ch.run_state;
        cmd.first_run = in_ch.first_run;
        cmd.distance = in_ch.distance;
        cmd.heading = in_ch.random_heading;
        sb.take_command(cmd);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.left = out_ch.left_drive;
        got.right = out_ch.right_drive;
        got.written = out_ch.drive_written;
        got.speed = out_ch.speed_setting;
        got.radius = out_ch.turn_radius;
        sb.check_drive(got);
      end
    end
  end

  // Watchdog: give up when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("differential_drive_mixer_core: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver switches between several stall patterns of random length.
  always @(negedge clk) begin
    if (rx_style_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_style_left = $urandom_range(50, 400);
    end else begin
      rx_style_left--;
    end
    rx_beat++;
    case (rx_style)
      RX_STEADY: out_ch.ready <= 1'b1;
      RX_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
      RX_STALLS: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          rx_hold = $urandom_range(1, 30);
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
      default: out_ch.ready <= (rx_beat % 4 == 0);
    endcase
  end

  function automatic logic signed [BYTE_W-1:0] pick_amount();
    int v;
    v = int'($urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 9))
        0: v = -128;
        1: v = -127;
        2: v = -126;
        3: v = -6;
        4: v = -5;
        5: v = 0;
        6: v = 5;
        7: v = 6;
        8: v = 126;
        default: v = 127;
      endcase
    end
    return BYTE_W'(v);
  endfunction

  // Distance readings that cluster around the obstacle threshold but mostly clear it.
  function automatic logic [BYTE_W-1:0] wander_distance();
    int ob;
    ob = int'(sb.obstacle_dist);
    case ($urandom_range(0, 7))
      0: return BYTE_W'(ob);
      1: return BYTE_W'(ob + 1);
      2: return BYTE_W'($urandom_range(0, 255));
      default: return (ob < 255) ? BYTE_W'($urandom_range(ob + 1, 255))
                                 : BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic command_t noise_command();
    command_t c;
    c.mode = MODE_W'($urandom_range(0, 7));
    c.amount = BYTE_W'($urandom_range(0, 255));
    c.run_state = 1'($urandom_range(0, 1));
    c.first_run = 1'($urandom_range(0, 1));
    c.distance = BYTE_W'($urandom_range(0, 255));
    c.heading = BYTE_W'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic command_t random_command();
    command_t c;
    c = noise_command();
    case ($urandom_range(0, 15))
      0, 1, 2:    c.mode = MODE_SET_SPEED;
      3, 4, 5:    c.mode = MODE_SET_STEER;
      6, 7, 8:    c.mode = MODE_ALTER_SPEED;
      9:          c.mode = MODE_STOP;
      10:         c.mode = MODE_RUN_STATE;
      11, 12, 13: c.mode = MODE_TICK;
      14:         c.mode = MODE_SPARE_LO;
      default:    c.mode = MODE_SPARE_HI;
    endcase
    c.amount = pick_amount();
    return c;
  endfunction

  // Present one command item, then keep the burst going or pause for a random gap.
  task automatic issue(command_t c);
    in_ch.valid <= 1'b1;
    in_ch.mode <= c.mode;
    in_ch.amount <= c.amount;
    in_ch.run_state <= c.run_state;
    in_ch.first_run <= c.first_run;
    in_ch.distance <= c.distance;
    in_ch.random_heading <= c.heading;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  task automatic issue_mode(logic [MODE_W-1:0] mode, logic signed [BYTE_W-1:0] amount);
    command_t c;
    c = noise_command();
    c.mode = mode;
    c.amount = amount;
    issue(c);
  endtask

  task automatic issue_tick(logic [BYTE_W-1:0] reading, logic signed [BYTE_W-1:0] heading);
    command_t c;
    c = noise_command();
    c.mode = MODE_TICK;
    c.distance = reading;
    c.heading = heading;
    issue(c);
  endtask

  task automatic issue_run(logic state, logic first);
    command_t c;
    c = noise_command();
    c.mode = MODE_RUN_STATE;
    c.run_state = state;
    c.first_run = first;
    issue(c);
  endtask

  // Stop sending and wait until every expected drive item has come back.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(int limit, int wspeed, int obst, int period);
    write_register(CFG_SPEED_LIMIT, BYTE_W'(limit));
    write_register(CFG_WANDER_SPEED, BYTE_W'(wspeed));
    write_register(CFG_OBST_DIST, BYTE_W'(obst));
    write_register(CFG_WANDER_PER, BYTE_W'(period));
  endtask

  // Mostly ordinary commands and wander trips, with some raw noise mixed in.
  task automatic random_traffic(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: issue(random_command());
        6, 7, 8: begin
          issue_run(RUN_WANDER, 1'($urandom_range(0, 1)));
          repeat ($urandom_range(3, 25)) begin
            if ($urandom_range(0, 7) == 0) begin
              issue(random_command());
            end else begin
              issue_tick(wander_distance(), BYTE_W'($urandom_range(0, 255)));
            end
          end
          if ($urandom_range(0, 1) == 1) begin
            issue_run(RUN_NORMAL, 1'($urandom_range(0, 1)));
            issue_tick(wander_distance(), BYTE_W'($urandom_range(0, 255)));
          end
        end
        default: issue(noise_command());
      endcase
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_SET_SPEED;
    in_ch.amount = '0;
    in_ch.run_state = RUN_NORMAL;
    in_ch.first_run = 1'b0;
    in_ch.distance = '0;
    in_ch.random_heading = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SPEED_LIMIT;
    cfg_ch.data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items at the reset configuration. Alter speed comes first,
    // while no speeds have been computed yet, so it must be ignored.
    issue_mode(MODE_ALTER_SPEED, 10);
    issue_tick(0, 0);
    issue_mode(MODE_SET_SPEED, 127);
    issue_mode(MODE_SET_SPEED, BYTE_W'(-128));
    issue_mode(MODE_SET_STEER, 0);
    issue_mode(MODE_SET_STEER, 5);
    issue_mode(MODE_SET_STEER, BYTE_W'(-5));
    issue_mode(MODE_SET_STEER, 6);
    issue_mode(MODE_SET_STEER, BYTE_W'(-6));
    issue_mode(MODE_SET_STEER, 127);
    issue_mode(MODE_SET_STEER, BYTE_W'(-127));
    issue_mode(MODE_SET_STEER, BYTE_W'(-128));
    issue_mode(MODE_ALTER_SPEED, 127);
    issue_mode(MODE_ALTER_SPEED, BYTE_W'(-128));
    issue_mode(MODE_SPARE_LO, 50);
    issue_mode(MODE_SPARE_HI, BYTE_W'(-50));
    issue_mode(MODE_STOP, 0);
    // Wander: first-run speed, back-off at the threshold and a clear tick just above it, then period expiry.
    issue_run(RUN_WANDER, 1'b1);
    issue_tick(255, 0);
    issue_tick(RST_OBST_DIST, 0);
    issue_tick(RST_OBST_DIST + 1'b1, 0);
    repeat (5) issue_tick(255, 127);
    issue_tick(255, BYTE_W'(-128));
    issue_run(RUN_NORMAL, 1'b0);
    issue_tick(255, 0);

    // Climb the requested speed past the top of its range, then back down past the bottom.
    issue_mode(MODE_SET_SPEED, 127);
    repeat (262) issue_mode(MODE_ALTER_SPEED, 127);
    repeat (8) issue_mode(MODE_ALTER_SPEED, BYTE_W'(-127));
    random_traffic(160);
    quiesce();

    // Widest limits and a full wander period: a long run of clear ticks.
    configure(255, 127, 0, 255);
    issue_run(RUN_WANDER, 1'b1);
    repeat (300) issue_tick(BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom_range(0, 255)));
    random_traffic(150);
    quiesce();

    configure(0, 0, 255, 0);
    random_traffic(160);
    quiesce();

    configure(1, 1, 1, 1);
    random_traffic(160);
    quiesce();

    repeat (3) begin
      configure($urandom_range(0, 255), $urandom_range(0, 127), $urandom_range(0, 80),
                $urandom_range(0, 12));
      random_traffic(160);
      quiesce();
    end

    // Let any stray result show up before the verdict.
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("differential_drive_mixer_core: match");
    end else begin
      $display("differential_drive_mixer_core: mismatch");
    end
    $finish;
  end

endmodule
